// File: rtl/murmur3_32bit_key_hash_macros.svh
// ---------------------------------------------------------------------------
// murmur3_32bit_key_hash assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MURMUR3_32BIT_KEY_HASH_MACROS_SVH
`define MURMUR3_32BIT_KEY_HASH_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising clock edge out of reset
`define MM3_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// expression must never be true out of reset
`define MM3_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define MM3_ASSERT(lbl, clk, rst_n, prop)
`define MM3_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: rtl/mm3_pkg.sv
// ---------------------------------------------------------------------------
// mm3_pkg
// Types and constants shared by the MurmurHash3 x86_32 key hasher.
// ---------------------------------------------------------------------------
package mm3_pkg;

	localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2 = 32'h1b873593;
	localparam logic [31:0] MM_N  = 32'he6546b64;
	localparam logic [31:0] MM_F1 = 32'h85ebca6b;
	localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

	localparam logic [2:0] FULL_BYTES = 3'd4;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int ADDR_W = 3;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_HASH_SEED = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last_item;
	} in_item_t;

	typedef struct packed {
		logic [31:0] hash_value;
		logic [31:0] key_length;
	} out_item_t;

	// scrambled key word with its clamped byte count
	typedef struct packed {
		logic [31:0] k;
		logic [2:0]  cnt;
		logic        last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: rtl/mm3_front.sv
// ---------------------------------------------------------------------------
// mm3_front
// Accepts key words, clamps and masks them, and runs the k scramble.
// ---------------------------------------------------------------------------
module mm3_front
	import mm3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     key_valid,
	output logic     key_ready,
	input  in_item_t key_word,
	input  q_stat_t  q_stat,
	output logic     push,
	output q_entry_t push_data
);

	logic [2:0]  cnt_c;
	logic        last_c;
	logic [31:0] masked_c;
	logic        en;

	logic        valid_s1, valid_s2;
	logic [31:0] word_s1, k1_s2;
	logic [2:0]  cnt_s1, cnt_s2;
	logic        last_s1, last_s2;
	logic [31:0] k1_rot;

	always_comb begin
		cnt_c = key_word.byte_count;
		if (key_word.byte_count inside {[3'd5:3'd7]}) begin
			cnt_c = FULL_BYTES;
		end
		// a short word always ends the key
		last_c = key_word.last_item || (cnt_c != FULL_BYTES);
		for (int i = 0; i < 4; i++) begin
			masked_c[8*i +: 8] = (3'(i) < cnt_c) ? key_word.data_word[8*i +: 8] : 8'h00;
		end
	end

	assign en        = !valid_s2 || !q_stat.full;
	assign key_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= key_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= masked_c;
			cnt_s1  <= cnt_c;
			last_s1 <= last_c;
			k1_s2   <= word_s1 * MM_C1;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	assign k1_rot = {k1_s2[16:0], k1_s2[31:17]};

	assign push           = valid_s2 && en;
	assign push_data.k    = k1_rot * MM_C2;
	assign push_data.cnt  = cnt_s2;
	assign push_data.last = last_s2;

endmodule

// File: rtl/mm3_fifo.sv
// ---------------------------------------------------------------------------
// mm3_fifo
// Small queue of scrambled words between the front and the back end.
// ---------------------------------------------------------------------------
`include "murmur3_32bit_key_hash_macros.svh"

module mm3_fifo
	import mm3_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	input  logic     pop,
	output q_entry_t rd_data,
	output q_stat_t  stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     fill_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full  = (fill_q == CNT_W'(DEPTH));
	assign stat.empty = (fill_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`MM3_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && stat.full)
	`MM3_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && stat.empty)
	`MM3_ASSERT(a_fill_tracks, clk, arst_n, (push && !pop) |=> (fill_q == $past(fill_q) + 1'b1))

endmodule

// File: rtl/mm3_back.sv
// ---------------------------------------------------------------------------
// mm3_back
// Running hash update, length XOR and avalanche finalizer with output reg.
// ---------------------------------------------------------------------------
module mm3_back
	import mm3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  q_stat_t     q_stat,
	input  q_entry_t    q_rd,
	output logic        pop,
	output logic        hash_valid,
	input  logic        hash_ready,
	output out_item_t   hash_result
);

	logic        en;
	logic        mid_key_q;
	logic [31:0] hash_q, total_q;
	logic [31:0] h_cur, tot_cur, h_new, tot_new, x, r, fa;

	logic        valid_s1, valid_s2, valid_s3, out_valid_q;
	logic [31:0] fin_s1, fin_s2, fin_s3;
	logic [31:0] len_s1, len_s2, len_s3;
	out_item_t   out_q;

	assign en  = !out_valid_q || hash_ready;
	assign pop = !q_stat.empty && en;

	always_comb begin
		h_cur   = mid_key_q ? hash_q : seed;
		tot_cur = mid_key_q ? total_q : '0;
		x       = h_cur ^ q_rd.k;
		r       = {x[18:0], x[31:19]};
		// short tail: k is already zero when no byte is valid
		h_new   = (q_rd.cnt == FULL_BYTES) ? (r + {r[29:0], 2'b00} + MM_N) : x;
		tot_new = tot_cur + 32'(q_rd.cnt);
		fa      = h_new ^ tot_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_key_q   <= 1'b0;
			hash_q      <= '0;
			total_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mid_key_q <= !q_rd.last;
				hash_q    <= h_new;
				total_q   <= tot_new;
			end
			if (en) begin
				valid_s1    <= pop && q_rd.last;
				valid_s2    <= valid_s1;
				valid_s3    <= valid_s2;
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s1           <= fa ^ (fa >> 16);
			len_s1           <= tot_new;
			fin_s2           <= fin_s1 * MM_F1;
			len_s2           <= len_s1;
			fin_s3           <= (fin_s2 ^ (fin_s2 >> 13)) * MM_F2;
			len_s3           <= len_s2;
			out_q.hash_value <= fin_s3 ^ (fin_s3 >> 16);
			out_q.key_length <= len_s3;
		end
	end

	assign hash_valid  = out_valid_q;
	assign hash_result = out_q;

endmodule

// File: rtl/murmur3_32bit_key_hash.sv
// ---------------------------------------------------------------------------
// murmur3_32bit_key_hash
// MurmurHash3 x86_32 over a key streamed as little-endian 32-bit words.
// ---------------------------------------------------------------------------
// Usage:
//   key channel (key_valid/key_ready/key_word): one word per item with a valid
//   byte count (0..4, larger counts act as 4) and a last flag. A word with
//   fewer than four bytes ends the key. Bytes at or above the count are ignored.
//   hash channel (hash_valid/hash_ready/hash_result): one item per key, holding
//   the finalized hash and the key length in bytes (mod 2^32).
//   APB port: register 0 (address 0) is hash_seed, sampled by a key's first word.
//   Write it only while no key is in flight.
// Timing: one key word per cycle sustained while the hash receiver keeps up. The
//   running hash update (xor, rotate, times five, add) is combinational in the
//   back end. From accepting the last word to hash_valid, the path runs through the
//   first scramble stage (loaded on the accepting edge), the second scramble stage,
//   the queue, the hash update, and three finalizer stages ending in the output reg.
// Reset: clears the seed, the queue and all valid flags; the next word starts
//   a key. A stalled receiver stops the back end; the queue then fills and
//   key_ready drops.
// ---------------------------------------------------------------------------
module murmur3_32bit_key_hash
	import mm3_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              key_valid,
	output logic              key_ready,
	input  in_item_t          key_word,
	output logic              hash_valid,
	input  logic              hash_ready,
	output out_item_t         hash_result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic        seed_wr;
	logic [31:0] seed_q;
	logic        push, pop;
	q_entry_t    push_data, q_rd;
	q_stat_t     q_stat;

	assign pready  = 1'b1;
	assign seed_wr = psel && penable && pwrite && (paddr[2] == REG_HASH_SEED);
	assign prdata  = (paddr[2] == REG_HASH_SEED) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_wr) begin
			seed_q <= pwdata;
		end
	end

	mm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_ready (key_ready),
		.key_word  (key_word),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	mm3_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.rd_data   (q_rd),
		.stat      (q_stat)
	);

	mm3_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed        (seed_q),
		.q_stat      (q_stat),
		.q_rd        (q_rd),
		.pop         (pop),
		.hash_valid  (hash_valid),
		.hash_ready  (hash_ready),
		.hash_result (hash_result)
	);

endmodule
